// ----- rtl/fsc_pkg.sv -----
// Package for the frustum sphere cull block: plane packing, widths,
// register map, result codes and the flag word carried along the cell chain.
// No dependencies.
package fsc_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int NUM_PLANES  = 6;
	localparam int COEF_BITS   = 12;
	localparam int DIST_BITS   = 28;
	localparam int FRAC_BITS   = 10;
	localparam int PLANE_W     = 64;

	localparam int COEF_A_LSB = 0;
	localparam int COEF_B_LSB = 12;
	localparam int COEF_C_LSB = 24;
	localparam int DIST_LSB   = 36;

	localparam int PADDR_W    = 6;
	localparam int REG_IDX_LSB = 3;
	localparam int REG_IDX_W  = PADDR_W - REG_IDX_LSB;
	localparam int PDATA_W    = 64;

	localparam int RESULT_W   = 2;
	localparam int OUT_TDATA_W = 8;

	typedef enum logic [RESULT_W-1:0] {
		CONT_INSIDE     = 2'd0,
		CONT_INTERSECTS = 2'd1,
		CONT_OUTSIDE    = 2'd2
	} containment_t;

	typedef struct packed {
		logic outside;
		logic crosses;
	} cull_flags_t;

endpackage

// ----- rtl/fsc_cell.sv -----
// One cell of the culling chain: holds one plane register and tests every
// passing sphere against it in four pipeline stages, merging its verdict.
// Depends on fsc_pkg.
module fsc_cell #(
	parameter int COORD_WIDTH = fsc_pkg::COORD_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [fsc_pkg::PLANE_W-1:0]   cfg_data,
	output logic [fsc_pkg::PLANE_W-1:0]   plane,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  logic signed [COORD_WIDTH-1:0] up_x,
	input  logic signed [COORD_WIDTH-1:0] up_y,
	input  logic signed [COORD_WIDTH-1:0] up_z,
	input  logic [COORD_WIDTH-2:0]        up_r,
	input  fsc_pkg::cull_flags_t          up_flags,
	output logic                          dn_valid,
	input  logic                          dn_ready,
	output logic signed [COORD_WIDTH-1:0] dn_x,
	output logic signed [COORD_WIDTH-1:0] dn_y,
	output logic signed [COORD_WIDTH-1:0] dn_z,
	output logic [COORD_WIDTH-2:0]        dn_r,
	output fsc_pkg::cull_flags_t          dn_flags
);

	localparam int CB     = fsc_pkg::COEF_BITS;
	localparam int PROD_W = CB + COORD_WIDTH;
	localparam int SUM_W  = PROD_W + 2;
	localparam int SHR_W  = SUM_W - fsc_pkg::FRAC_BITS;
	localparam int DIST_W = ((SHR_W > fsc_pkg::DIST_BITS) ? SHR_W : fsc_pkg::DIST_BITS) + 1;
	localparam int CMP_W  = DIST_W + 1;

	logic [fsc_pkg::PLANE_W-1:0] plane_q;

	logic signed [CB-1:0]                   coef_a, coef_b, coef_c;
	logic signed [fsc_pkg::DIST_BITS-1:0]   coef_d;

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	logic signed [COORD_WIDTH-1:0] x_s1, y_s1, z_s1, x_s2, y_s2, z_s2;
	logic signed [COORD_WIDTH-1:0] x_s3, y_s3, z_s3, x_s4, y_s4, z_s4;
	logic [COORD_WIDTH-2:0]        r_s1, r_s2, r_s3, r_s4;
	fsc_pkg::cull_flags_t          flags_s1, flags_s2, flags_s3, flags_s4;

	logic signed [PROD_W-1:0] pa_s1, pb_s1, pc_s1;
	logic signed [SUM_W-1:0]  dot_s2;
	logic signed [SHR_W-1:0]  dot_shr;
	logic signed [DIST_W-1:0] dist_s3;
	logic signed [CMP_W-1:0]  dist_ext, rad_ext, dist_plus_r;
	logic                     outside_c, crosses_c;

	assign plane  = plane_q;
	assign coef_a = plane_q[fsc_pkg::COEF_A_LSB +: CB];
	assign coef_b = plane_q[fsc_pkg::COEF_B_LSB +: CB];
	assign coef_c = plane_q[fsc_pkg::COEF_C_LSB +: CB];
	assign coef_d = plane_q[fsc_pkg::DIST_LSB +: fsc_pkg::DIST_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q <= '0;
		end else if (cfg_we) begin
			plane_q <= cfg_data;
		end
	end

	assign adv_s4   = !v_s4 || dn_ready;
	assign adv_s3   = !v_s3 || adv_s4;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign up_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= up_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
		end
	end

	assign dot_shr     = dot_s2[SUM_W-1:fsc_pkg::FRAC_BITS];
	assign dist_ext    = CMP_W'(dist_s3);
	assign rad_ext     = CMP_W'(r_s3);
	assign dist_plus_r = dist_ext + rad_ext;
	assign outside_c   = dist_plus_r < 0;
	assign crosses_c   = (dist_plus_r > 0) && (dist_ext < rad_ext);

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pa_s1    <= PROD_W'(coef_a) * PROD_W'(up_x);
			pb_s1    <= PROD_W'(coef_b) * PROD_W'(up_y);
			pc_s1    <= PROD_W'(coef_c) * PROD_W'(up_z);
			x_s1     <= up_x;
			y_s1     <= up_y;
			z_s1     <= up_z;
			r_s1     <= up_r;
			flags_s1 <= up_flags;
		end
		if (adv_s2) begin
			dot_s2   <= SUM_W'(pa_s1) + SUM_W'(pb_s1) + SUM_W'(pc_s1);
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			z_s2     <= z_s1;
			r_s2     <= r_s1;
			flags_s2 <= flags_s1;
		end
		if (adv_s3) begin
			dist_s3  <= DIST_W'(coef_d) + DIST_W'(dot_shr);
			x_s3     <= x_s2;
			y_s3     <= y_s2;
			z_s3     <= z_s2;
			r_s3     <= r_s2;
			flags_s3 <= flags_s2;
		end
		if (adv_s4) begin
			x_s4             <= x_s3;
			y_s4             <= y_s3;
			z_s4             <= z_s3;
			r_s4             <= r_s3;
			flags_s4.outside <= flags_s3.outside | outside_c;
			flags_s4.crosses <= flags_s3.crosses | crosses_c;
		end
	end

	assign dn_valid = v_s4;
	assign dn_x     = x_s4;
	assign dn_y     = y_s4;
	assign dn_z     = z_s4;
	assign dn_r     = r_s4;
	assign dn_flags = flags_s4;

endmodule

// ----- rtl/frustum_sphere_cull.sv -----
// Top level of the frustum sphere cull block: APB plane registers, a chain
// of six plane cells and the result register. Depends on fsc_pkg, fsc_cell.
//
// Usage: a sphere word enters on s_axis (center x, y, z and radius) and one
// result word leaves on m_axis holding the containment code: inside,
// intersects or outside the frustum. The six planes are written through the
// APB port, 64 bits each at byte address 8 times the plane index; the user
// must write them only while no sphere is in flight; the block does not
// enforce this. Writes beyond the sixth plane are ignored and read back as zero.
// Each of the six cells tests one plane in four register stages, and the
// output register follows the last cell before m_axis. One sphere is
// accepted every cycle while results are taken. When the receiver
// stalls, the result waits in the output register and the chain keeps
// accepting spheres until every stage in front of it holds a word.
// Reset clears all planes to zero and empties the chain and output register.
module frustum_sphere_cull #(
	parameter int COORD_WIDTH = fsc_pkg::COORD_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// center_x, center_y, center_z, sphere_radius from bit 0 up, zero padded
	input  logic [((4*COORD_WIDTH-1)+7)/8*8-1:0] s_axis_tdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// containment in bits 1:0, zero padded
	output logic [fsc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fsc_pkg::PADDR_W-1:0]         paddr,
	input  logic [fsc_pkg::PDATA_W-1:0]         pwdata,
	output logic [fsc_pkg::PDATA_W-1:0]         prdata,
	output logic                                pready
);

	localparam int NP = fsc_pkg::NUM_PLANES;

	logic [NP:0]                   ch_valid, ch_ready;
	logic signed [COORD_WIDTH-1:0] ch_x [NP+1];
	logic signed [COORD_WIDTH-1:0] ch_y [NP+1];
	logic signed [COORD_WIDTH-1:0] ch_z [NP+1];
	logic [COORD_WIDTH-2:0]        ch_r [NP+1];
	fsc_pkg::cull_flags_t          ch_flags [NP+1];

	logic [fsc_pkg::PLANE_W-1:0]   plane_rd [NP];
	logic [NP-1:0]                 cfg_we;
	logic                          apb_wr;
	logic [fsc_pkg::REG_IDX_W-1:0] reg_idx;

	logic                  out_valid_q;
	fsc_pkg::containment_t containment_q;
	fsc_pkg::containment_t containment_c;

	assign pready  = 1'b1;
	assign apb_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[fsc_pkg::PADDR_W-1:fsc_pkg::REG_IDX_LSB];

	always_comb begin
		prdata = '0;
		cfg_we = '0;
		for (int i = 0; i < NP; i++) begin
			if (reg_idx == fsc_pkg::REG_IDX_W'(i)) begin
				prdata    = plane_rd[i];
				cfg_we[i] = apb_wr;
			end
		end
	end

	assign ch_valid[0]   = s_axis_tvalid;
	assign s_axis_tready = ch_ready[0];
	assign ch_x[0]       = s_axis_tdata[0 +: COORD_WIDTH];
	assign ch_y[0]       = s_axis_tdata[COORD_WIDTH +: COORD_WIDTH];
	assign ch_z[0]       = s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH];
	assign ch_r[0]       = s_axis_tdata[3*COORD_WIDTH +: COORD_WIDTH-1];
	assign ch_flags[0]   = '0;

	for (genvar g = 0; g < NP; g++) begin : g_chain
		fsc_cell #(
			.COORD_WIDTH (COORD_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cfg_we   (cfg_we[g]),
			.cfg_data (pwdata),
			.plane    (plane_rd[g]),
			.up_valid (ch_valid[g]),
			.up_ready (ch_ready[g]),
			.up_x     (ch_x[g]),
			.up_y     (ch_y[g]),
			.up_z     (ch_z[g]),
			.up_r     (ch_r[g]),
			.up_flags (ch_flags[g]),
			.dn_valid (ch_valid[g+1]),
			.dn_ready (ch_ready[g+1]),
			.dn_x     (ch_x[g+1]),
			.dn_y     (ch_y[g+1]),
			.dn_z     (ch_z[g+1]),
			.dn_r     (ch_r[g+1]),
			.dn_flags (ch_flags[g+1])
		);
	end

	assign ch_ready[NP] = !out_valid_q || m_axis_tready;

	always_comb begin
		priority if (ch_flags[NP].outside) begin
			containment_c = fsc_pkg::CONT_OUTSIDE;
		end else if (ch_flags[NP].crosses) begin
			containment_c = fsc_pkg::CONT_INTERSECTS;
		end else begin
			containment_c = fsc_pkg::CONT_INSIDE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ch_ready[NP]) begin
			out_valid_q <= ch_valid[NP];
		end
	end

	always_ff @(posedge clk) begin
		if (ch_ready[NP] && ch_valid[NP]) begin
			containment_q <= containment_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = fsc_pkg::OUT_TDATA_W'(containment_q);

endmodule
